// File: design/hdcp_pkg.sv
// Shared types and constants of the HID descriptor collection parser.
package hdcp_pkg;

    // Item prefix fields and codes
    localparam logic [7:0] LONG_PREFIX     = 8'hFE;
    localparam logic [1:0] SIZE_FOUR       = 2'd3;
    localparam logic [1:0] TYPE_MAIN       = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL     = 2'd1;
    localparam logic [1:0] TYPE_LOCAL      = 2'd2;
    localparam logic [3:0] TAG_GLOBAL_PAGE = 4'h0;
    localparam logic [3:0] TAG_LOCAL_ID    = 4'h0;
    localparam logic [3:0] TAG_MAIN_OPEN   = 4'hA;
    localparam logic [3:0] TAG_MAIN_CLOSE  = 4'hC;

    // Result kinds
    localparam logic KIND_COLLECTION = 1'b0;
    localparam logic KIND_SUMMARY    = 1'b1;

    // Reset value of the expected collection count
    localparam logic [7:0] EXPECTED_RESET = 8'd6;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  collection_number;
        logic [15:0] hid_page;
        logic [15:0] usage;
        logic [7:0]  collection_type;
        logic [7:0]  total_collections;
        logic        matches_expected;
        logic        last_result;
    } t_result;

endpackage

// File: design/hdcp_if.sv
// Channel interfaces: descriptor bytes in, results out, configuration writes.
interface hdcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hdcp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  collection_number;
    logic [15:0] hid_page;
    logic [15:0] usage;
    logic [7:0]  collection_type;
    logic [7:0]  total_collections;
    logic        matches_expected;
    logic        last_result;

    modport source (output valid, output kind, output collection_number,
                    output hid_page, output usage, output collection_type,
                    output total_collections, output matches_expected,
                    output last_result, input ready);
    modport sink (input valid, input kind, input collection_number,
                  input hid_page, input usage, input collection_type,
                  input total_collections, input matches_expected,
                  input last_result, output ready);
endinterface

interface hdcp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/hid_descriptor_collection_parser_unit.sv
// A result is written into the result queue when its byte is accepted and is offered from the queue head.
// Throughput: one descriptor byte per cycle while input ready is high; a byte with two
//   results leaves both to be popped one at a time, and input ready drops while the
//   four-entry result queue has fewer than two free slots.
// Reset (i_rst_n low, synchronous): parser state and queue clear, the expected
//   count returns to 6; no clearing pass, the block takes bytes right after reset.
module hid_descriptor_collection_parser_unit #(
    parameter int DEPTH_BITS = 8,
    parameter int COUNT_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hdcp_in_if.sink   i_item,
    hdcp_cfg_if.sink  i_cfg,
    hdcp_out_if.source o_result
);
    import hdcp_pkg::*;

    logic [7:0]           r_expected;
    t_result              r_queue [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] n_count;

    logic       w_accept;
    logic       w_pop;
    logic [1:0] w_res_valid;
    t_result    w_res0;
    t_result    w_res1;
    t_result    w_head;

    // Accept configuration at any time; write the expected count
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= EXPECTED_RESET;
        end else if (i_cfg.valid) begin
            r_expected <= i_cfg.data;
        end
    end

    // Take a byte while the queue has room for two results
    assign i_item.ready = (r_count <= QCNT_BITS'(QUEUE_DEPTH - 2));
    assign w_accept     = i_item.valid && i_item.ready;

    hdcp_parse #(
        .DEPTH_BITS (DEPTH_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_item.data_byte),
        .i_last_byte (i_item.last_byte),
        .i_expected  (r_expected),
        .o_res_valid (w_res_valid),
        .o_res0      (w_res0),
        .o_res1      (w_res1)
    );

    // Queue results; pop the head when the sink takes it
    assign w_pop   = o_result.valid && o_result.ready;
    assign n_count = r_count + QCNT_BITS'(w_res_valid[0]) + QCNT_BITS'(w_res_valid[1])
                     - QCNT_BITS'(w_pop);

    always_ff @(posedge i_clk) begin
        if (w_res_valid[0]) begin
            r_queue[r_wr_ptr] <= w_res0;
        end
        if (w_res_valid[1]) begin
            r_queue[r_wr_ptr + QPTR_BITS'(1)] <= w_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_BITS'(w_res_valid[0]) + QPTR_BITS'(w_res_valid[1]);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            r_count <= n_count;
        end
    end

    // Drive the output channel from the queue head
    assign w_head                     = r_queue[r_rd_ptr];
    assign o_result.valid             = (r_count != '0);
    assign o_result.kind              = w_head.kind;
    assign o_result.collection_number = w_head.collection_number;
    assign o_result.hid_page          = w_head.hid_page;
    assign o_result.usage             = w_head.usage;
    assign o_result.collection_type   = w_head.collection_type;
    assign o_result.total_collections = w_head.total_collections;
    assign o_result.matches_expected  = w_head.matches_expected;
    assign o_result.last_result       = w_head.last_result;

    // Queue never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // A second result of one byte is always the summary behind a first one
    a_second_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid[1] |-> (w_res_valid[0] && w_res1.kind == KIND_SUMMARY
                            && w_res0.kind == KIND_COLLECTION))
        else $error("second result is not a summary after a collection");

    // A result that is not the byte's last always has its partner queued behind it
    a_partner_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.last_result) |-> (r_count >= QCNT_BITS'(2)))
        else $error("collection result without its summary");

    // A pop with no push shrinks the queue by one
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_res_valid == 2'b00) |=> (r_count == $past(r_count) - QCNT_BITS'(1)))
        else $error("queue count off after pop");

endmodule

// File: design/hdcp_parse.sv
// Byte-wise item parser: prefix split, data gather, usage and nesting tracking.
module hdcp_parse #(
    parameter int DEPTH_BITS = 8,
    parameter int COUNT_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic [7:0]        i_expected,
    output logic [1:0]        o_res_valid,
    output hdcp_pkg::t_result o_res0,
    output hdcp_pkg::t_result o_res1
);
    import hdcp_pkg::*;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_DATA,
        PH_LONGLEN,
        PH_SKIP
    } t_phase;

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0]        COUNT_MAX = '1;

    t_phase                        r_phase, n_phase;
    logic [8:0]                    r_left, n_left;
    logic [1:0]                    r_type, n_type;
    logic [3:0]                    r_tag, n_tag;
    logic [1:0]                    r_pos, n_pos;
    logic [15:0]                   r_accum, n_accum;
    logic [15:0]                   r_page, n_page;
    logic [15:0]                   r_usage, n_usage;
    logic signed [DEPTH_BITS-1:0]  r_depth, n_depth;
    logic [COUNT_BITS-1:0]         r_count, n_count;

    logic        w_done;
    logic        w_found;
    logic [15:0] w_count16;
    t_result     w_col;
    t_result     w_sum;

    // Decode the byte against the current phase and finish complete items
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_type  = r_type;
        n_tag   = r_tag;
        n_pos   = r_pos;
        n_accum = r_accum;
        n_page  = r_page;
        n_usage = r_usage;
        n_depth = r_depth;
        n_count = r_count;
        w_done  = 1'b0;
        w_found = 1'b0;

        unique case (r_phase)
            PH_PREFIX: begin
                if (i_data_byte == LONG_PREFIX) begin
                    n_phase = PH_LONGLEN;
                end else begin
                    n_type  = i_data_byte[3:2];
                    n_tag   = i_data_byte[7:4];
                    n_left  = (i_data_byte[1:0] == SIZE_FOUR) ? 9'd4 : {7'd0, i_data_byte[1:0]};
                    n_pos   = 2'd0;
                    n_accum = 16'd0;
                    if (i_data_byte[1:0] == 2'd0) begin
                        w_done = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                // only the low two bytes of the data ever matter
                if (r_pos == 2'd0) begin
                    n_accum[7:0] = i_data_byte;
                end
                if (r_pos == 2'd1) begin
                    n_accum[15:8] = i_data_byte;
                end
                n_pos  = r_pos + 2'd1;
                n_left = r_left - 9'd1;
                if (r_left == 9'd1) begin
                    w_done = 1'b1;
                end
            end
            PH_LONGLEN: begin
                n_left  = {1'b0, i_data_byte} + 9'd1;
                n_phase = PH_SKIP;
            end
            PH_SKIP: begin
                if (r_left != 9'd0) begin
                    n_left = r_left - 9'd1;
                end
                if (n_left == 9'd0) begin
                    n_phase = PH_PREFIX;
                end
            end
            default: n_phase = PH_PREFIX;
        endcase

        // Act on a complete short item
        if (w_done) begin
            n_phase = PH_PREFIX;
            if (n_type == TYPE_GLOBAL && n_tag == TAG_GLOBAL_PAGE) begin
                n_page = n_accum;
            end else if (n_type == TYPE_LOCAL && n_tag == TAG_LOCAL_ID) begin
                n_usage = n_accum;
            end else if (n_type == TYPE_MAIN && n_tag == TAG_MAIN_OPEN) begin
                if (r_depth == '0) begin
                    w_found = 1'b1;
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                end
                if (r_depth != DEPTH_MAX) begin
                    n_depth = r_depth + 1'b1;
                end
            end else if (n_type == TYPE_MAIN && n_tag == TAG_MAIN_CLOSE) begin
                if (r_depth != DEPTH_MIN) begin
                    n_depth = r_depth - 1'b1;
                end
            end
        end
    end

    // Build the results of this byte
    assign w_count16 = 16'(n_count);

    always_comb begin
        w_col                   = '0;
        w_col.kind              = KIND_COLLECTION;
        w_col.collection_number = w_count16[7:0];
        w_col.hid_page          = r_page;
        w_col.usage             = r_usage;
        w_col.collection_type   = n_accum[7:0];
        w_col.last_result       = !i_last_byte;

        w_sum                   = '0;
        w_sum.kind              = KIND_SUMMARY;
        w_sum.total_collections = w_count16[7:0];
        w_sum.matches_expected  = (w_count16 == 16'(i_expected));
        w_sum.last_result       = 1'b1;
    end

    // Pack results so the first one always sits in slot 0
    always_comb begin
        o_res_valid = 2'b00;
        o_res0      = w_col;
        o_res1      = w_sum;
        if (i_accept) begin
            if (w_found) begin
                o_res_valid = {i_last_byte, 1'b1};
            end else if (i_last_byte) begin
                o_res_valid = 2'b01;
                o_res0      = w_sum;
            end
        end
    end

    // Hold parser state; clear it on reset and after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_phase <= PH_PREFIX;
            r_left  <= '0;
            r_type  <= '0;
            r_tag   <= '0;
            r_pos   <= '0;
            r_accum <= '0;
            r_page  <= '0;
            r_usage <= '0;
            r_depth <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_type  <= n_type;
            r_tag   <= n_tag;
            r_pos   <= n_pos;
            r_accum <= n_accum;
            r_page  <= n_page;
            r_usage <= n_usage;
            r_depth <= n_depth;
            r_count <= n_count;
        end
    end

endmodule
